[hdl/open_addressing_hash_table_defines.svh]
// Assertion macros used by the checker file of the hash table.
`ifndef OPEN_ADDRESSING_HASH_TABLE_DEFINES_SVH
`define OPEN_ADDRESSING_HASH_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define OAHT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define OAHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/oaht_pkg.sv]
// Types, constants and helper functions of the open-addressing hash table.
package oaht_pkg;

  localparam int BUCKETS_DEF = 64;
  localparam int KEY_BYTES   = 8;
  localparam int HASH_W      = 12;
  localparam int LIMIT_RESET = 48;

  localparam logic [HASH_W-1:0] FNV_BASIS_LO = HASH_W'(64'd14695981039346656037);
  localparam logic [HASH_W-1:0] FNV_PRIME_LO = HASH_W'(64'd1099511628211);

  typedef enum logic [1:0] {
    REQ_LOOKUP  = 2'd0,
    REQ_INSERT  = 2'd1,
    REQ_DELETE  = 2'd2,
    REQ_ITERATE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_MISS     = 2'd1,
    ST_INSERTED = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_LIVE  = 2'd1,
    MARK_GRAVE = 2'd2,
    MARK_UNUSED = 2'd3
  } mark_t;

  typedef struct packed {
    req_t              req;
    logic [63:0]       key;
    logic [3:0]        klen;
    logic [31:0]       value;
    logic [6:0]        start;
    logic [HASH_W-1:0] hash;
  } entry_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] value;
    logic [63:0] key;
    logic [3:0]  klen;
    logic [5:0]  slot;
    logic [6:0]  next;
    logic [6:0]  live;
    logic [6:0]  grave;
  } res_t;

  function automatic logic [63:0] key_mask(input logic [3:0] len);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      m[8*i +: 8] = (4'(i) < len) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

  function automatic logic [HASH_W-1:0] hash_step(input logic [HASH_W-1:0] h,
                                                  input logic [7:0] b);
    logic [HASH_W-1:0] x;
    x = h ^ HASH_W'(b);
    return HASH_W'(x * FNV_PRIME_LO);
  endfunction

endpackage

[hdl/open_addressing_hash_table.sv]
// Flow: the front end accepts a request and hashes its key one byte per cycle; the request then
// waits in the queue, and per probed slot the back end does a registered slot-store read, then evaluates it.
// Overlap: the front end can hash a new key while the back end still probes for an earlier one;
// the slower side sets the rate, and a two-entry queue lets them overlap.
// Reset: synchronous, active low; afterwards a clearing pass over all BUCKETS slots empties
// the slot marks, during which no request is accepted.
module open_addressing_hash_table #(
  parameter int BUCKETS = oaht_pkg::BUCKETS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [63:0] in_key_bytes,
  input  logic [3:0]  in_key_len,
  input  logic [31:0] in_new_value,
  input  logic [6:0]  in_start_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_value,
  output logic [63:0] out_key,
  output logic [3:0]  out_key_len,
  output logic [5:0]  out_slot_index,
  output logic [6:0]  out_next_index,
  output logic [6:0]  out_live_count,
  output logic [6:0]  out_grave_count
);

  logic [6:0]       load_limit_r;
  logic             push, full, pop, empty, clearing;
  oaht_pkg::entry_t push_data, head;
  oaht_pkg::res_t   res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_limit_r <= 7'(oaht_pkg::LIMIT_RESET);
    end else if (cfg_wr_en) begin
      load_limit_r <= cfg_wr_data;
    end
  end

  oaht_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .hold           (clearing),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_key_bytes   (in_key_bytes),
    .in_key_len     (in_key_len),
    .in_new_value   (in_new_value),
    .in_start_index (in_start_index),
    .push           (push),
    .push_data      (push_data),
    .full           (full)
  );

  oaht_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  oaht_back #(
    .BUCKETS (BUCKETS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_limit (load_limit_r),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .clearing   (clearing),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .res        (res)
  );

  assign out_status      = res.status;
  assign out_value       = res.value;
  assign out_key         = res.key;
  assign out_key_len     = res.klen;
  assign out_slot_index  = res.slot;
  assign out_next_index  = res.next;
  assign out_live_count  = res.live;
  assign out_grave_count = res.grave;

endmodule

[hdl/oaht_fifo.sv]
// Two-entry queue that carries hashed requests from the front to the back.
module oaht_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  oaht_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output oaht_pkg::entry_t head,
  output logic            empty
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);

  oaht_pkg::entry_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   count_r;
  logic          do_push, do_pop;

  assign full    = count_r == (PW+1)'(DEPTH);
  assign empty   = count_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        mem_r[wr_ptr_r] <= push_data;
        wr_ptr_r        <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

[hdl/oaht_front.sv]
// Front end: accepts requests, normalises the key and hashes it one byte per cycle.
module oaht_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             hold,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_req_type,
  input  logic [63:0]      in_key_bytes,
  input  logic [3:0]       in_key_len,
  input  logic [31:0]      in_new_value,
  input  logic [6:0]       in_start_index,
  output logic             push,
  output oaht_pkg::entry_t push_data,
  input  logic             full
);

  typedef enum logic {F_IDLE, F_HASH} fstate_t;

  fstate_t          state_r;
  oaht_pkg::entry_t ent_r;
  logic [3:0]       cnt_r;
  logic [3:0]       klen_c;
  logic             accept;

  assign klen_c    = (in_key_len > 4'(oaht_pkg::KEY_BYTES)) ? 4'(oaht_pkg::KEY_BYTES)
                                                           : in_key_len;
  assign in_ready  = (state_r == F_IDLE) && !hold;
  assign accept    = in_valid && in_ready;
  assign push      = (state_r == F_HASH) && (cnt_r == ent_r.klen) && !full;
  assign push_data = ent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (accept) begin
            ent_r.req   <= oaht_pkg::req_t'(in_req_type);
            ent_r.klen  <= klen_c;
            ent_r.key   <= in_key_bytes & oaht_pkg::key_mask(klen_c);
            ent_r.value <= in_new_value;
            ent_r.start <= in_start_index;
            ent_r.hash  <= oaht_pkg::FNV_BASIS_LO;
            cnt_r       <= '0;
            state_r     <= F_HASH;
          end
        end
        F_HASH: begin
          if (cnt_r != ent_r.klen) begin
            ent_r.hash <= oaht_pkg::hash_step(ent_r.hash, ent_r.key[8*cnt_r[2:0] +: 8]);
            cnt_r      <= cnt_r + 4'd1;
          end else if (!full) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

[hdl/oaht_back.sv]
// Back end: clears the slot marks after reset and walks the probe sequence per request.
module oaht_back #(
  parameter int BUCKETS = oaht_pkg::BUCKETS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [6:0]       load_limit,
  input  oaht_pkg::entry_t head,
  input  logic             empty,
  output logic             pop,
  output logic             clearing,
  output logic             out_valid,
  input  logic             out_ready,
  output oaht_pkg::res_t   res
);

  localparam int IW = $clog2(BUCKETS);
  localparam int CW = $clog2(BUCKETS + 1);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ, S_EVAL} bstate_t;

  bstate_t          state_r;
  oaht_pkg::entry_t ent_r;
  oaht_pkg::res_t   res_r;
  logic             out_valid_r;
  logic [IW-1:0]    pos_r, n_r, clr_r, grave_pos_r;
  logic             have_grave_r;
  logic [CW-1:0]    live_r, grave_r;

  oaht_pkg::mark_t  mark_mem [BUCKETS];
  logic [63:0]      key_mem  [BUCKETS];
  logic [3:0]       klen_mem [BUCKETS];
  logic [31:0]      val_mem  [BUCKETS];
  oaht_pkg::mark_t  rd_mark;
  logic [63:0]      rd_key;
  logic [3:0]       rd_klen;
  logic [31:0]      rd_val;

  logic             mark_we, kv_we, val_we;
  logic [IW-1:0]    wa;
  oaht_pkg::mark_t  mark_wd;
  logic [31:0]      val_wd;

  logic             is_empty, is_live, is_grave, match, last, grave_any, empty_ok;
  logic [IW-1:0]    gpos;
  logic [CW:0]      sum;

  function automatic oaht_pkg::res_t mk_res(input oaht_pkg::status_t st,
                                            input logic [31:0] v,
                                            input logic [63:0] k,
                                            input logic [3:0] kl,
                                            input logic [IW-1:0] s,
                                            input logic [IW:0] nx,
                                            input logic [CW-1:0] lv,
                                            input logic [CW-1:0] gv);
    oaht_pkg::res_t r;
    r.status = st;
    r.value  = v;
    r.key    = k;
    r.klen   = kl;
    r.slot   = 6'(s);
    r.next   = 7'(nx);
    r.live   = 7'(lv);
    r.grave  = 7'(gv);
    return r;
  endfunction

  assign clearing  = state_r == S_CLEAR;
  assign pop       = (state_r == S_IDLE) && !empty && !out_valid_r;
  assign out_valid = out_valid_r;
  assign res       = res_r;

  assign is_empty  = rd_mark == oaht_pkg::MARK_EMPTY;
  assign is_live   = rd_mark == oaht_pkg::MARK_LIVE;
  assign is_grave  = rd_mark == oaht_pkg::MARK_GRAVE;
  assign match     = is_live && (rd_klen == ent_r.klen) && (rd_key == ent_r.key);
  assign last      = n_r == IW'(BUCKETS - 1);
  assign grave_any = have_grave_r || is_grave;
  assign gpos      = have_grave_r ? grave_pos_r : pos_r;
  assign sum       = (CW+1)'(live_r) + (CW+1)'(grave_r) + (CW+1)'(1);
  assign empty_ok  = is_empty && (32'(sum) <= 32'(load_limit));

  always_comb begin
    mark_we = 1'b0;
    kv_we   = 1'b0;
    val_we  = 1'b0;
    wa      = pos_r;
    mark_wd = oaht_pkg::MARK_EMPTY;
    val_wd  = ent_r.value;
    case (state_r)
      S_CLEAR: begin
        mark_we = 1'b1;
        wa      = clr_r;
      end
      S_EVAL: begin
        case (ent_r.req)
          oaht_pkg::REQ_INSERT: begin
            if (match) begin
              val_we = 1'b1;
            end else if (is_empty || last) begin
              if (grave_any) begin
                wa      = gpos;
                mark_we = 1'b1;
                kv_we   = 1'b1;
                val_we  = 1'b1;
                mark_wd = oaht_pkg::MARK_LIVE;
              end else if (empty_ok) begin
                mark_we = 1'b1;
                kv_we   = 1'b1;
                val_we  = 1'b1;
                mark_wd = oaht_pkg::MARK_LIVE;
              end
            end
          end
          oaht_pkg::REQ_DELETE: begin
            if (match) begin
              mark_we = 1'b1;
              mark_wd = oaht_pkg::MARK_GRAVE;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mark_we) begin
      mark_mem[wa] <= mark_wd;
    end
    if (kv_we) begin
      key_mem[wa]  <= ent_r.key;
      klen_mem[wa] <= ent_r.klen;
    end
    if (val_we) begin
      val_mem[wa] <= val_wd;
    end
    rd_mark <= mark_mem[pos_r];
    rd_key  <= key_mem[pos_r];
    rd_klen <= klen_mem[pos_r];
    rd_val  <= val_mem[pos_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      out_valid_r  <= 1'b0;
      live_r       <= '0;
      grave_r      <= '0;
      have_grave_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == IW'(BUCKETS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pop) begin
            ent_r        <= head;
            n_r          <= '0;
            have_grave_r <= 1'b0;
            if (head.req == oaht_pkg::REQ_ITERATE) begin
              pos_r <= IW'(head.start);
              if (32'(head.start) >= BUCKETS) begin
                res_r       <= mk_res(oaht_pkg::ST_MISS, '0, '0, '0, '0,
                                      (IW+1)'(BUCKETS), live_r, grave_r);
                out_valid_r <= 1'b1;
              end else begin
                state_r <= S_READ;
              end
            end else begin
              pos_r   <= head.hash[IW-1:0];
              state_r <= S_READ;
            end
          end
        end
        S_READ: begin
          state_r <= S_EVAL;
        end
        S_EVAL: begin
          case (ent_r.req)
            oaht_pkg::REQ_ITERATE: begin
              if (is_live) begin
                res_r       <= mk_res(oaht_pkg::ST_HIT, rd_val, rd_key, rd_klen, pos_r,
                                      (IW+1)'(pos_r) + (IW+1)'(1), live_r, grave_r);
                out_valid_r <= 1'b1;
                state_r     <= S_IDLE;
              end else if (pos_r == IW'(BUCKETS - 1)) begin
                res_r       <= mk_res(oaht_pkg::ST_MISS, '0, '0, '0, '0,
                                      (IW+1)'(BUCKETS), live_r, grave_r);
                out_valid_r <= 1'b1;
                state_r     <= S_IDLE;
              end else begin
                pos_r   <= pos_r + 1'b1;
                state_r <= S_READ;
              end
            end
            oaht_pkg::REQ_INSERT: begin
              if (match) begin
                res_r       <= mk_res(oaht_pkg::ST_HIT, rd_val, '0, '0, pos_r, '0,
                                      live_r, grave_r);
                out_valid_r <= 1'b1;
                state_r     <= S_IDLE;
              end else if (is_empty || last) begin
                if (grave_any) begin
                  live_r      <= live_r + 1'b1;
                  grave_r     <= grave_r - 1'b1;
                  res_r       <= mk_res(oaht_pkg::ST_INSERTED, ent_r.value, '0, '0, gpos,
                                        '0, live_r + 1'b1, grave_r - 1'b1);
                end else if (empty_ok) begin
                  live_r      <= live_r + 1'b1;
                  res_r       <= mk_res(oaht_pkg::ST_INSERTED, ent_r.value, '0, '0, pos_r,
                                        '0, live_r + 1'b1, grave_r);
                end else begin
                  res_r       <= mk_res(oaht_pkg::ST_FULL, '0, '0, '0, '0, '0,
                                        live_r, grave_r);
                end
                out_valid_r <= 1'b1;
                state_r     <= S_IDLE;
              end else begin
                if (is_grave && !have_grave_r) begin
                  have_grave_r <= 1'b1;
                  grave_pos_r  <= pos_r;
                end
                pos_r   <= pos_r + 1'b1;
                n_r     <= n_r + 1'b1;
                state_r <= S_READ;
              end
            end
            default: begin
              if (match) begin
                if (ent_r.req == oaht_pkg::REQ_DELETE) begin
                  live_r  <= live_r - 1'b1;
                  grave_r <= grave_r + 1'b1;
                  res_r   <= mk_res(oaht_pkg::ST_HIT, rd_val, '0, '0, pos_r, '0,
                                    live_r - 1'b1, grave_r + 1'b1);
                end else begin
                  res_r   <= mk_res(oaht_pkg::ST_HIT, rd_val, '0, '0, pos_r, '0,
                                    live_r, grave_r);
                end
                out_valid_r <= 1'b1;
                state_r     <= S_IDLE;
              end else if (is_empty || last) begin
                res_r       <= mk_res(oaht_pkg::ST_MISS, '0, '0, '0, '0, '0,
                                      live_r, grave_r);
                out_valid_r <= 1'b1;
                state_r     <= S_IDLE;
              end else begin
                pos_r   <= pos_r + 1'b1;
                n_r     <= n_r + 1'b1;
                state_r <= S_READ;
              end
            end
          endcase
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[hdl/oaht_checker.sv]
// Port-level checker for the hash table and its bind to the top level.
`include "open_addressing_hash_table_defines.svh"

module oaht_checker #(
  parameter int BUCKETS = oaht_pkg::BUCKETS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [31:0] out_value,
  input logic [5:0]  out_slot_index,
  input logic [6:0]  out_live_count,
  input logic [6:0]  out_grave_count
);

  `OAHT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(out_status), "Result beat changed while stalled.")
  `OAHT_ASSERT_NOW(a_full_zero, out_valid && (out_status == oaht_pkg::ST_FULL), (out_value == 32'd0) && (out_slot_index == 6'd0), "Refused insert carries a value or slot.")
  `OAHT_ASSERT_NOW(a_miss_zero, out_valid && (out_status == oaht_pkg::ST_MISS), (out_value == 32'd0) && (out_slot_index == 6'd0), "Miss carries a value or slot.")
  `OAHT_ASSERT_NOW(a_count_bound, out_valid, (32'(out_live_count) + 32'(out_grave_count)) <= BUCKETS, "Live plus tombstone count exceeds the table size.")

endmodule

bind open_addressing_hash_table oaht_checker #(.BUCKETS(BUCKETS)) u_oaht_checker (.*);

[verif/tb.sv]
// Self-checking testbench of the open-addressing hash table, with its own table predictor.
`timescale 1ns / 1ps
module tb;
  import oaht_pkg::*;

  localparam int NB = 64;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic [1:0]  req;
    logic [63:0] key;
    logic [3:0]  klen;
    logic [31:0] nval;
    logic [6:0]  start;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value;
    logic [63:0] key;
    logic [3:0]  klen;
    logic [5:0]  slot;
    logic [6:0]  next;
    logic [6:0]  live;
    logic [6:0]  grave;
  } response_t;

  logic clk = 0, rst_n = 0;
  logic cfg_wr_en = 0;
  logic [6:0] cfg_wr_data = '0;
  logic in_valid = 0, in_ready;
  logic [1:0] in_req_type = '0;
  logic [63:0] in_key_bytes = '0;
  logic [3:0] in_key_len = '0;
  logic [31:0] in_new_value = '0;
  logic [6:0] in_start_index = '0;
  logic out_valid, out_ready = 0;
  logic [1:0] out_status;
  logic [31:0] out_value;
  logic [63:0] out_key;
  logic [3:0] out_key_len;
  logic [5:0] out_slot_index;
  logic [6:0] out_next_index, out_live_count, out_grave_count;

  always #6 clk = ~clk;

  open_addressing_hash_table DUT (.*);

  mark_t       tbl_mark[NB];
  logic [63:0] tbl_key[NB];
  logic [3:0]  tbl_klen[NB];
  logic [31:0] tbl_val[NB];
  int unsigned tbl_live, tbl_grave, tbl_limit;

  request_t  pending_reqs[$];
  response_t expected_resps[$];
  logic [63:0] key_pool[16];
  logic [3:0]  klen_pool[16];
  int mismatches = 0, unexpected = 0, idle_cycles = 0;
  int burst_left = 0, gap_left = 0;

  function automatic logic [5:0] fnv_bucket(logic [63:0] k, int unsigned n);
    logic [63:0] h;
    h = 64'd14695981039346656037;
    for (int i = 0; i < n; i++) begin
      h = h ^ {56'd0, k[8*i +: 8]};
      h = h * 64'd1099511628211;
    end
    return h[5:0];
  endfunction

  function automatic response_t predict_table(request_t r);
    response_t o;
    int unsigned n, pos, gpos, epos;
    logic [63:0] k;
    bit hg, he, done;
    n = (r.klen > 8) ? 8 : r.klen;
    k = (n >= 8) ? r.key : (r.key & ((64'd1 << (8 * n)) - 1));
    pos = fnv_bucket(k, n);
    o = '0;
    o.status = ST_MISS;
    hg = 0; he = 0; done = 0; gpos = 0; epos = 0;
    if (r.req == REQ_ITERATE) begin
      o.next = NB;
      for (int i = r.start; i < NB; i++) begin
        if (tbl_mark[i] == MARK_LIVE) begin
          o.status = ST_HIT; o.value = tbl_val[i]; o.key = tbl_key[i];
          o.klen = tbl_klen[i]; o.slot = i; o.next = i + 1;
          break;
        end
      end
    end else if (r.req == REQ_INSERT) begin
      for (int s = 0; s < NB; s++) begin
        if (tbl_mark[pos] == MARK_EMPTY) begin
          he = 1; epos = pos; break;
        end
        if (tbl_mark[pos] == MARK_GRAVE) begin
          if (!hg) begin hg = 1; gpos = pos; end
        end else if (tbl_klen[pos] == n && tbl_key[pos] == k) begin
          o.status = ST_HIT; o.value = tbl_val[pos]; o.slot = pos;
          tbl_val[pos] = r.nval; done = 1; break;
        end
        pos = (pos + 1) % NB;
      end
      if (!done) begin
        if (hg || (he && tbl_live + tbl_grave + 1 <= tbl_limit)) begin
          if (hg) begin epos = gpos; tbl_grave--; end
          tbl_mark[epos] = MARK_LIVE; tbl_key[epos] = k; tbl_klen[epos] = n;
          tbl_val[epos] = r.nval; tbl_live++;
          o.status = ST_INSERTED; o.value = r.nval; o.slot = epos;
        end else begin
          o.status = ST_FULL;
        end
      end
    end else begin
      for (int s = 0; s < NB; s++) begin
        if (tbl_mark[pos] == MARK_EMPTY) break;
        if (tbl_mark[pos] == MARK_LIVE && tbl_klen[pos] == n && tbl_key[pos] == k) begin
          o.status = ST_HIT; o.value = tbl_val[pos]; o.slot = pos;
          if (r.req == REQ_DELETE) begin
            tbl_mark[pos] = MARK_GRAVE; tbl_val[pos] = 0; tbl_live--; tbl_grave++;
          end
          break;
        end
        pos = (pos + 1) % NB;
      end
    end
    o.live = tbl_live;
    o.grave = tbl_grave;
    return o;
  endfunction

  task automatic queue_req(logic [1:0] rq, logic [63:0] k, logic [3:0] l,
                           logic [31:0] v, logic [6:0] s);
    request_t r;
    r.req = rq; r.key = k; r.klen = l; r.nval = v; r.start = s;
    pending_reqs.push_back(r);
  endtask

  task automatic drain_and_config(logic [6:0] lim);
    while (pending_reqs.size() != 0 || expected_resps.size() != 0 || in_valid)
      @(posedge clk);
    repeat (400) @(posedge clk);
    cfg_wr_en <= 1;
    cfg_wr_data <= lim;
    @(posedge clk);
    cfg_wr_en <= 0;
    tbl_limit = lim;
  endtask

  task automatic random_phase(int count);
    logic [1:0] rq;
    int p;
    for (int i = 0; i < count; i++) begin
      p = $urandom_range(0, 15);
      rq = $urandom_range(0, 9) < 4 ? REQ_INSERT : 2'($urandom);
      if ($urandom_range(0, 9) == 0)
        queue_req(rq, {$urandom, $urandom}, 4'($urandom), $urandom, 7'($urandom));
      else
        queue_req(rq, key_pool[p] | ({$urandom, $urandom} << 8 * klen_pool[p]) &
                  {64{klen_pool[p] < 8}}, klen_pool[p] | ($urandom_range(0, 9) == 0 &&
                  klen_pool[p] == 8 ? 4'($urandom_range(9, 15)) : 4'd0),
                  $urandom, 7'($urandom_range(0, 66)));
    end
  endtask

  // Driver: bursts of beats with random gaps.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        request_t done_r;
        done_r = {in_req_type, in_key_bytes, in_key_len, in_new_value, in_start_index};
        expected_resps.push_back(predict_table(done_r));
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 0;
        end else if (pending_reqs.size() != 0) begin
          request_t r;
          r = pending_reqs.pop_front();
          in_valid <= 1;
          in_req_type <= r.req; in_key_bytes <= r.key; in_key_len <= r.klen;
          in_new_value <= r.nval; in_start_index <= r.start;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 30);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // Monitor: checks each result beat and stalls the receiver on its own pattern.
  always @(posedge clk) begin
    if (rst_n) begin
      out_ready <= ($urandom_range(0, 199) < 100) ? 1'b1 : ($urandom_range(0, 3) != 0);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && out_ready) begin
        response_t got, want;
        got = {out_status, out_value, out_key, out_key_len, out_slot_index,
               out_next_index, out_live_count, out_grave_count};
        if (expected_resps.size() == 0) begin
          unexpected++;
          $display("Unexpected result beat %h", got);
        end else begin
          want = expected_resps.pop_front();
          if (got !== want) begin
            if (mismatches < 10)
              $display("Mismatch: expected %h, actual %h", want, got);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    foreach (tbl_mark[i]) begin
      tbl_mark[i] = MARK_EMPTY; tbl_key[i] = '0; tbl_klen[i] = '0; tbl_val[i] = '0;
    end
    tbl_live = 0; tbl_grave = 0; tbl_limit = LIMIT_RESET;
    for (int i = 0; i < 16; i++) begin
      klen_pool[i] = (i < 9) ? i : $urandom_range(0, 8);
      key_pool[i] = {$urandom, $urandom} &
                    ((klen_pool[i] >= 8) ? '1 : ((64'd1 << 8 * klen_pool[i]) - 1));
    end
    repeat (6) @(posedge clk);
    rst_n <= 1;
    queue_req(REQ_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h0, 7'd0);
    queue_req(REQ_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'hFFFF_FFFF, 7'd127);
    queue_req(REQ_INSERT, 64'h0, 4'd0, 32'h0, 7'd0);
    queue_req(REQ_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 32'h1234_5678, 7'd0);
    queue_req(REQ_INSERT, 64'hAB, 4'd1, 32'h5555_AAAA, 7'd0);
    queue_req(REQ_LOOKUP, 64'hFFFF_FFFF_FFFF_FFAB, 4'd1, 32'h0, 7'd0);
    queue_req(REQ_ITERATE, 64'h0, 4'd0, 32'h0, 7'd0);
    queue_req(REQ_ITERATE, 64'h0, 4'd0, 32'h0, 7'd63);
    queue_req(REQ_ITERATE, 64'h0, 4'd0, 32'h0, 7'd64);
    queue_req(REQ_ITERATE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 32'hFFFF_FFFF, 7'd127);
    queue_req(REQ_DELETE, 64'hAB, 4'd1, 32'h0, 7'd0);
    queue_req(REQ_DELETE, 64'hAB, 4'd1, 32'h0, 7'd0);
    queue_req(REQ_LOOKUP, 64'hAB, 4'd2, 32'h0, 7'd0);
    queue_req(REQ_INSERT, 64'hAB, 4'd1, 32'h0BAD_CAFE, 7'd0);
    queue_req(REQ_DELETE, 64'h0, 4'd0, 32'h0, 7'd0);
    random_phase(200);
    drain_and_config(7'd1);
    queue_req(REQ_INSERT, 64'h77, 4'd1, 32'h1, 7'd0);
    random_phase(150);
    drain_and_config(7'd0);
    queue_req(REQ_INSERT, 64'h99, 4'd1, 32'h1, 7'd0);
    random_phase(150);
    drain_and_config(7'd64);
    random_phase(350);
    drain_and_config(7'd127);
    random_phase(150);
    drain_and_config(7'($urandom_range(2, 63)));
    random_phase(250);
    while (pending_reqs.size() != 0 || expected_resps.size() != 0 || in_valid)
      @(posedge clk);
    repeat (400) @(posedge clk);
    if (mismatches == 0 && unexpected == 0 && expected_resps.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

[open_addressing_hash_table.f]
+incdir+hdl
hdl/oaht_pkg.sv
hdl/oaht_fifo.sv
hdl/oaht_front.sv
hdl/oaht_back.sv
hdl/open_addressing_hash_table.sv
hdl/oaht_checker.sv
verif/tb.sv
